// ===== rtl/button_debounce_auto_repeat_defines.svh =====
// Assertion macros for the button debounce block checkers.
// Depends on nothing; included by the checker file.
`ifndef BUTTON_DEBOUNCE_AUTO_REPEAT_DEFINES_SVH
`define BUTTON_DEBOUNCE_AUTO_REPEAT_DEFINES_SVH

// Same-cycle implication, skipped while reset is low.
`define BDAR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bdar check failed");

// Next-cycle implication, skipped while reset is low.
`define BDAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bdar check failed");

`endif

// ===== rtl/bdar_pkg.sv =====
// Shared types, widths, register codes and reset values for the button debounce block.
// No dependencies.
`timescale 1ns / 1ps
package bdar_pkg;

    localparam int TIME_WIDTH   = 16;
    localparam int STEP_WIDTH   = 8;
    localparam int PERIOD_WIDTH = 10;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int TDATA_W      = 8;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_ENABLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_AFTER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FASTER_STEPS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_PERIOD   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_PERIOD   = 3'd6;

    localparam logic                    RST_ACTIVE_LOW    = 1'b1;
    localparam logic [TIME_WIDTH-1:0]   RST_COOLDOWN      = 16'd50;
    localparam logic                    RST_REPEAT_ENABLE = 1'b0;
    localparam logic [TIME_WIDTH-1:0]   RST_START_AFTER   = 16'd500;
    localparam logic [STEP_WIDTH-1:0]   RST_FASTER_STEPS  = 8'd5;
    localparam logic [PERIOD_WIDTH-1:0] RST_SLOW_PERIOD   = 10'd200;
    localparam logic [PERIOD_WIDTH-1:0] RST_FAST_PERIOD   = 10'd50;

    typedef struct packed {
        logic                    active_low;
        logic [TIME_WIDTH-1:0]   cooldown_ms;
        logic                    repeat_enable;
        logic [TIME_WIDTH-1:0]   start_after_ms;
        logic [STEP_WIDTH-1:0]   faster_steps;
        logic [PERIOD_WIDTH-1:0] slow_period_ms;
        logic [PERIOD_WIDTH-1:0] fast_period_ms;
    } t_cfg;

    typedef struct packed {
        logic repeating;
        logic held_block;
        logic fire;
    } t_res;

    function automatic logic [TIME_WIDTH-1:0] sat_inc_time(input logic [TIME_WIDTH-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [STEP_WIDTH-1:0] sat_inc_step(input logic [STEP_WIDTH-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

endpackage

// ===== rtl/button_debounce_auto_repeat.sv =====
// Button debounce with auto-repeat, one millisecond tick per input item.
// A result item is registered and valid the cycle after its tick item is accepted.
// Throughput: one item per cycle; the single output register stalls intake only
// while it is full and not being taken.
// Reset: synchronous active low; clears state and output valid, loads register defaults.
// Depends on bdar_pkg, bdar_cfg, bdar_core, bdar_out.
`timescale 1ns / 1ps
module button_debounce_auto_repeat (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [bdar_pkg::TDATA_W-1:0]    s_axis_tdata,   // [0] pin_level
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [bdar_pkg::TDATA_W-1:0]    m_axis_tdata,   // [0] fire, [1] held_block, [2] repeating
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bdar_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bdar_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bdar_pkg::*;

    t_cfg cfg;
    t_res res;
    logic accept;
    logic space;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = space;
    assign accept        = s_axis_tvalid && space;

    bdar_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_idx   (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    bdar_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_pin_level (s_axis_tdata[0]),
        .i_cfg       (cfg),
        .o_res       (res)
    );

    bdar_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_res    (res),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_space  (space)
    );

endmodule

// ===== rtl/bdar_cfg.sv =====
// Configuration register file of the button debounce block.
// Depends on bdar_pkg.
`timescale 1ns / 1ps
module bdar_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr,
    input  logic [bdar_pkg::CFG_IDX_W-1:0]  i_idx,
    input  logic [bdar_pkg::CFG_DATA_W-1:0] i_data,
    output bdar_pkg::t_cfg                  o_cfg
);
    import bdar_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_low     <= RST_ACTIVE_LOW;
            r_cfg.cooldown_ms    <= RST_COOLDOWN;
            r_cfg.repeat_enable  <= RST_REPEAT_ENABLE;
            r_cfg.start_after_ms <= RST_START_AFTER;
            r_cfg.faster_steps   <= RST_FASTER_STEPS;
            r_cfg.slow_period_ms <= RST_SLOW_PERIOD;
            r_cfg.fast_period_ms <= RST_FAST_PERIOD;
        end else if (i_wr) begin
            case (i_idx)
                REG_ACTIVE_LOW:    r_cfg.active_low     <= i_data[0];
                REG_COOLDOWN:      r_cfg.cooldown_ms    <= i_data[TIME_WIDTH-1:0];
                REG_REPEAT_ENABLE: r_cfg.repeat_enable  <= i_data[0];
                REG_START_AFTER:   r_cfg.start_after_ms <= i_data[TIME_WIDTH-1:0];
                REG_FASTER_STEPS:  r_cfg.faster_steps   <= i_data[STEP_WIDTH-1:0];
                REG_SLOW_PERIOD:   r_cfg.slow_period_ms <= i_data[PERIOD_WIDTH-1:0];
                REG_FAST_PERIOD:   r_cfg.fast_period_ms <= i_data[PERIOD_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/bdar_core.sv =====
// Debounce and auto-repeat state with its per-tick update logic.
// Depends on bdar_pkg.
`timescale 1ns / 1ps
module bdar_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic           i_pin_level,
    input  bdar_pkg::t_cfg i_cfg,
    output bdar_pkg::t_res o_res
);
    import bdar_pkg::*;

    logic                  r_blocked, n_blocked;
    logic [TIME_WIDTH-1:0] r_since_press, n_since_press;
    logic [TIME_WIDTH-1:0] r_since_mark, n_since_mark;
    logic                  r_repeat_active, n_repeat_active;
    logic [STEP_WIDTH-1:0] r_step_count, n_step_count;
    logic                  pressed;
    logic                  fire;
    logic [TIME_WIDTH-1:0] sp_inc, sm_inc;

    always_comb begin
        pressed         = i_pin_level ^ i_cfg.active_low;
        sp_inc          = sat_inc_time(r_since_press);
        sm_inc          = sat_inc_time(r_since_mark);
        n_blocked       = r_blocked;
        n_since_press   = sp_inc;
        n_since_mark    = sm_inc;
        n_repeat_active = r_repeat_active;
        n_step_count    = r_step_count;
        fire            = 1'b0;
        if (pressed && !r_blocked) begin
            n_since_press = '0;
            n_blocked     = 1'b1;
            n_step_count  = sat_inc_step(r_step_count);
            fire          = 1'b1;
        end else if (r_blocked && !pressed && (sp_inc >= i_cfg.cooldown_ms)) begin
            n_blocked = 1'b0;
        end else if (i_cfg.repeat_enable) begin
            if (!r_blocked) begin
                n_since_mark    = '0;
                n_repeat_active = 1'b0;
                n_step_count    = '0;
            end else if (!r_repeat_active) begin
                if (sm_inc >= i_cfg.start_after_ms) begin
                    n_since_mark    = '0;
                    n_repeat_active = 1'b1;
                    n_step_count    = sat_inc_step(r_step_count);
                    fire            = 1'b1;
                end
            end else if (r_step_count < i_cfg.faster_steps) begin
                if (sm_inc >= TIME_WIDTH'(i_cfg.slow_period_ms)) begin
                    n_since_mark = '0;
                    n_step_count = sat_inc_step(r_step_count);
                    fire         = 1'b1;
                end
            end else if (sm_inc >= TIME_WIDTH'(i_cfg.fast_period_ms)) begin
                n_since_mark = '0;
                fire         = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocked       <= 1'b0;
            r_since_press   <= '0;
            r_since_mark    <= '0;
            r_repeat_active <= 1'b0;
            r_step_count    <= '0;
        end else if (i_accept) begin
            r_blocked       <= n_blocked;
            r_since_press   <= n_since_press;
            r_since_mark    <= n_since_mark;
            r_repeat_active <= n_repeat_active;
            r_step_count    <= n_step_count;
        end
    end

    assign o_res.fire       = fire;
    assign o_res.held_block = n_blocked;
    assign o_res.repeating  = n_repeat_active & i_cfg.repeat_enable;

endmodule

// ===== rtl/bdar_out.sv =====
// Output register stage for result items.
// Depends on bdar_pkg.
`timescale 1ns / 1ps
module bdar_out (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  bdar_pkg::t_res               i_res,
    input  logic                         i_tready,
    output logic                         o_tvalid,
    output logic [bdar_pkg::TDATA_W-1:0] o_tdata,
    output logic                         o_space
);
    import bdar_pkg::*;

    logic r_valid;
    t_res r_res;

    assign o_space = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {{(TDATA_W - $bits(t_res)){1'b0}}, r_res};

endmodule

// ===== rtl/bdar_chk.sv =====
// Port-level checker for the button debounce block, bound to the top level.
// Depends on bdar_pkg and button_debounce_auto_repeat_defines.svh.
`timescale 1ns / 1ps
`include "button_debounce_auto_repeat_defines.svh"
module bdar_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [bdar_pkg::TDATA_W-1:0] m_axis_tdata
);
    import bdar_pkg::*;

    `BDAR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `BDAR_ASSERT_NOW(a_fire_blocks, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[1])
    `BDAR_ASSERT_NEXT(a_accept_gives_result, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, m_axis_tvalid)
    `BDAR_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)

endmodule

bind button_debounce_auto_repeat bdar_chk u_bdar_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
